/* rtl/tmta_pkg.sv */
// ---------------------------------------------------------------------------
// tmta_pkg: shared constants and types of the trimmed-mean filter
// Field widths, scaling constants and the stage-enable bundle.
// ---------------------------------------------------------------------------
package tmta_pkg;

	localparam int SAMPLES_DEF = 8;     // items per window
	localparam int IN_W        = 16;    // raw sample width
	localparam int SUM_W       = 23;    // running sum width
	localparam int T_W         = 22;    // trimmed sum, |T| <= 62 * 32768
	localparam int MAG_W       = 25;    // |15 * T| < 2**25
	localparam int SCALE       = 15;    // 0.15 uT per LSB in hundredths
	localparam int RECIP_SHIFT = 31;    // reciprocal fraction bits
	localparam int RECIP_W     = 32;    // reciprocal width (holds 2**31)
	localparam int PROD_W      = MAG_W + RECIP_W;
	localparam int OUT_W       = 20;    // result field width

	// load enables for the post-window stages
	typedef struct packed {
		logic en2;   // scale and magnitude
		logic en3;   // reciprocal multiply
		logic en4;   // result register
	} stage_en_t;

endpackage

/* rtl/trimmed_mean_three_axis.sv */
// ---------------------------------------------------------------------------
// trimmed_mean_three_axis: windowed trimmed-mean magnetometer filter
// Per-axis running sum/min/max with a short pipeline to 0.01 uT units.
// ---------------------------------------------------------------------------
// Usage:
//   Sample channel (sample_valid/sample_ready) carries one word of three
//   signed 16-bit raw axis samples. Every SAMPLES words form a window.
//   At the end of a window one field word (field_valid/field_ready) is
//   produced: per axis, (sum - min - max) / (SAMPLES - 2), scaled by 15
//   to hundredths of a microtesla, truncated toward zero, x negated.
//   SAMPLES = 1 passes samples through, SAMPLES = 2 gives the plain mean.
// Throughput: one sample word per clock cycle, except while a closing word
//   waits (see Stall). Each accepted word updates the per-axis sum/min/max
//   registers. The edge that accepts the last word of a window captures the
//   trimmed sum; the field word then moves through the scale, multiply and
//   result registers as each stage ahead frees up.
// Stall: the post-window stages are elastic; a stalled field word holds
//   steady. Words that do not close a window are always taken; a closing
//   word waits only when every stage ahead is full.
// Reset: arst_n clears the window count and all stage valids; the first
//   word after reset opens a new window.
// ---------------------------------------------------------------------------
module trimmed_mean_three_axis #(
	parameter int SAMPLES = tmta_pkg::SAMPLES_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  sample_valid,
	output logic                                  sample_ready,
	input  logic signed [tmta_pkg::IN_W-1:0]      mag_x,
	input  logic signed [tmta_pkg::IN_W-1:0]      mag_y,
	input  logic signed [tmta_pkg::IN_W-1:0]      mag_z,
	output logic                                  field_valid,
	input  logic                                  field_ready,
	output logic signed [tmta_pkg::OUT_W-1:0]     field_x,
	output logic signed [tmta_pkg::OUT_W-1:0]     field_y,
	output logic signed [tmta_pkg::OUT_W-1:0]     field_z
);

	localparam int WIN   = (SAMPLES < 1) ? 1 : SAMPLES;
	localparam bit TRIM  = (WIN >= 3);
	localparam int DIV   = TRIM ? WIN - 2 : WIN;
	localparam int CNT_W = (WIN > 1) ? $clog2(WIN) : 1;
	localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(WIN - 1);

	logic [CNT_W-1:0]    count_q;
	logic                first;
	logic                last;
	logic                take;
	logic                capture;

	// stage valids: s1 trimmed sum, s2 magnitude, s3 product, s4 result
	logic                v1_q, v2_q, v3_q, v4_q;
	logic                rdy1, rdy2, rdy3, rdy4;
	tmta_pkg::stage_en_t en;

	assign first = (count_q == '0);
	assign last  = (count_q == LAST_CNT);

	// backpressure ripples back through empty-or-moving stages
	assign rdy4 = !v4_q || field_ready;
	assign rdy3 = !v3_q || rdy4;
	assign rdy2 = !v2_q || rdy3;
	assign rdy1 = !v1_q || rdy2;

	assign sample_ready = !last || rdy1;
	assign take         = sample_valid && sample_ready;
	assign capture      = take && last;

	assign en.en2 = v1_q && rdy2;
	assign en.en3 = v2_q && rdy3;
	assign en.en4 = v3_q && rdy4;

	assign field_valid = v4_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			v1_q    <= 1'b0;
			v2_q    <= 1'b0;
			v3_q    <= 1'b0;
			v4_q    <= 1'b0;
		end else begin
			if (take) begin
				count_q <= last ? '0 : count_q + 1'b1;
			end
			if (rdy1) v1_q <= capture;
			if (rdy2) v2_q <= v1_q;
			if (rdy3) v3_q <= v2_q;
			if (rdy4) v4_q <= v3_q;
		end
	end

	logic signed [tmta_pkg::T_W-1:0] trim_x_s1, trim_y_s1, trim_z_s1;

	tmta_axis #(.TRIM(TRIM)) u_axis_x (
		.clk(clk), .take(take), .first(first), .capture(capture),
		.sample(mag_x), .trim_s1(trim_x_s1)
	);
	tmta_axis #(.TRIM(TRIM)) u_axis_y (
		.clk(clk), .take(take), .first(first), .capture(capture),
		.sample(mag_y), .trim_s1(trim_y_s1)
	);
	tmta_axis #(.TRIM(TRIM)) u_axis_z (
		.clk(clk), .take(take), .first(first), .capture(capture),
		.sample(mag_z), .trim_s1(trim_z_s1)
	);

	// x is reported with inverted sense
	tmta_scale #(.DIV(DIV), .NEGATE(1'b1)) u_scale_x (
		.clk(clk), .en(en), .trim_s1(trim_x_s1), .field_q(field_x)
	);
	tmta_scale #(.DIV(DIV), .NEGATE(1'b0)) u_scale_y (
		.clk(clk), .en(en), .trim_s1(trim_y_s1), .field_q(field_y)
	);
	tmta_scale #(.DIV(DIV), .NEGATE(1'b0)) u_scale_z (
		.clk(clk), .en(en), .trim_s1(trim_z_s1), .field_q(field_z)
	);

endmodule

/* rtl/tmta_axis.sv */
// ---------------------------------------------------------------------------
// tmta_axis: per-axis window accumulator
// Running sum, min and max; captures the trimmed sum at window end.
// ---------------------------------------------------------------------------
module tmta_axis #(
	parameter bit TRIM = 1'b1
) (
	input  logic                                  clk,
	input  logic                                  take,    // word accepted
	input  logic                                  first,   // first word of window
	input  logic                                  capture, // last word, load s1
	input  logic signed [tmta_pkg::IN_W-1:0]      sample,
	output logic signed [tmta_pkg::T_W-1:0]       trim_s1
);

	logic signed [tmta_pkg::SUM_W-1:0] sum_q;
	logic signed [tmta_pkg::IN_W-1:0]  min_q;
	logic signed [tmta_pkg::IN_W-1:0]  max_q;
	logic signed [tmta_pkg::SUM_W-1:0] sample_ext;
	logic signed [tmta_pkg::SUM_W-1:0] sum_nxt;
	logic signed [tmta_pkg::IN_W-1:0]  min_nxt;
	logic signed [tmta_pkg::IN_W-1:0]  max_nxt;
	logic signed [tmta_pkg::SUM_W-1:0] trim_nxt;

	assign sample_ext = tmta_pkg::SUM_W'(sample);

	always_comb begin
		if (first) begin
			sum_nxt = sample_ext;
			min_nxt = sample;
			max_nxt = sample;
		end else begin
			sum_nxt = sum_q + sample_ext;
			min_nxt = (sample < min_q) ? sample : min_q;
			max_nxt = (sample > max_q) ? sample : max_q;
		end
		// one copy of each extreme drops out
		if (TRIM) begin
			trim_nxt = sum_nxt - tmta_pkg::SUM_W'(min_nxt) - tmta_pkg::SUM_W'(max_nxt);
		end else begin
			trim_nxt = sum_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			sum_q <= sum_nxt;
			min_q <= min_nxt;
			max_q <= max_nxt;
		end
		if (capture) begin
			trim_s1 <= trim_nxt[tmta_pkg::T_W-1:0];
		end
	end

endmodule

/* rtl/tmta_scale.sv */
// ---------------------------------------------------------------------------
// tmta_scale: per-axis scaling and constant divide
// Scales by 15, divides by the window divisor through a reciprocal
// multiply, and applies the sign (negated for the x axis).
// ---------------------------------------------------------------------------
module tmta_scale #(
	parameter int DIV    = 6,
	parameter bit NEGATE = 1'b0
) (
	input  logic                                  clk,
	input  tmta_pkg::stage_en_t                   en,
	input  logic signed [tmta_pkg::T_W-1:0]       trim_s1,
	output logic signed [tmta_pkg::OUT_W-1:0]     field_q
);

	// ceil(2**31 / DIV): exact floor for magnitudes below 2**25
	localparam longint RECIP_L =
		((longint'(1) <<< tmta_pkg::RECIP_SHIFT) + longint'(DIV) - 1) / longint'(DIV);
	localparam logic [tmta_pkg::RECIP_W-1:0] RECIP = tmta_pkg::RECIP_W'(RECIP_L);

	logic signed [tmta_pkg::MAG_W:0]    scaled;
	logic [tmta_pkg::MAG_W-1:0]         mag_s2;
	logic                               neg_s2;
	logic                               neg_s3;
	logic [tmta_pkg::PROD_W-1:0]        prod_s3;
	logic [tmta_pkg::OUT_W-1:0]         quot;

	assign scaled = (tmta_pkg::MAG_W+1)'(trim_s1) * (tmta_pkg::MAG_W+1)'(tmta_pkg::SCALE);
	assign quot   = prod_s3[tmta_pkg::RECIP_SHIFT +: tmta_pkg::OUT_W];

	always_ff @(posedge clk) begin
		if (en.en2) begin
			neg_s2 <= trim_s1[tmta_pkg::T_W-1] ^ NEGATE;
			mag_s2 <= scaled[tmta_pkg::MAG_W] ? tmta_pkg::MAG_W'(-scaled)
			                                  : scaled[tmta_pkg::MAG_W-1:0];
		end
		if (en.en3) begin
			neg_s3  <= neg_s2;
			prod_s3 <= tmta_pkg::PROD_W'(mag_s2) * tmta_pkg::PROD_W'(RECIP);
		end
		if (en.en4) begin
			field_q <= neg_s3 ? -quot : quot;
		end
	end

endmodule

/* rtl/tmta_checker.sv */
// ---------------------------------------------------------------------------
// tmta_checker: port-level checks for the trimmed-mean filter
// Handshake behavior on both channels and result range.
// ---------------------------------------------------------------------------
module tmta_checker (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  sample_valid,
	input  logic                                  sample_ready,
	input  logic signed [tmta_pkg::IN_W-1:0]      mag_x,
	input  logic signed [tmta_pkg::IN_W-1:0]      mag_y,
	input  logic signed [tmta_pkg::IN_W-1:0]      mag_z,
	input  logic                                  field_valid,
	input  logic                                  field_ready,
	input  logic signed [tmta_pkg::OUT_W-1:0]     field_x,
	input  logic signed [tmta_pkg::OUT_W-1:0]     field_y,
	input  logic signed [tmta_pkg::OUT_W-1:0]     field_z
);

	localparam logic signed [tmta_pkg::OUT_W-1:0] FIELD_MAX = 20'sd491520;
	localparam logic signed [tmta_pkg::OUT_W-1:0] FIELD_MIN = -20'sd491520;

	a_sample_hold: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && !sample_ready |=>
			sample_valid && $stable(mag_x) && $stable(mag_y) && $stable(mag_z))
		else $error("sample word dropped or changed while waiting");

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		field_valid && !field_ready |=> field_valid)
		else $error("field word dropped while stalled");

	a_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		field_valid && !field_ready |=>
			$stable(field_x) && $stable(field_y) && $stable(field_z))
		else $error("field word changed while stalled");

	a_x_range: assert property (@(posedge clk) disable iff (!arst_n)
		field_valid |-> (field_x <= FIELD_MAX) && (field_x >= FIELD_MIN))
		else $error("field_x out of range");

	a_yz_range: assert property (@(posedge clk) disable iff (!arst_n)
		field_valid |-> (field_y <= FIELD_MAX) && (field_y >= FIELD_MIN) &&
			(field_z <= FIELD_MAX) && (field_z >= FIELD_MIN))
		else $error("field_y or field_z out of range");

endmodule

bind trimmed_mean_three_axis tmta_checker u_tmta_checker (.*);
